// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge out of reset.
`define TFSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tfsl assertion failed");

// Condition must never be seen at a rising edge out of reset.
`define TFSL_ASSERT_NEVER(lbl, cond) \
  `TFSL_ASSERT(lbl, !(cond))

`endif

// ===== rtl/tfsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsl_pkg
// Widths, register map, reset values and shared types of the throttle filter.
// ----------------------------------------------------------------------------
package tfsl_pkg;

  localparam int ADC_BITS  = 12;
  localparam int PWM_BITS  = 12;
  localparam int FRAC_BITS = 16;
  localparam int FILT_W    = ADC_BITS + FRAC_BITS;   // Q12.16 average
  localparam int TIME_W    = 32;
  localparam int DUTY_W    = 32;                     // Q0.32 duty
  localparam int ALPHA_W   = 16;
  localparam int RAMP_W    = 16;
  localparam int IVL_W     = 20;
  localparam int MUL_W     = 32;                     // shared multiplier operands
  localparam int PROD_W    = 2 * MUL_W;
  localparam int TGT_W     = FILT_W + DUTY_W - FRAC_BITS;
  localparam int LIM_W     = TIME_W + RAMP_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DUTY_W-1:0] PWM_MAX = DUTY_W'((64'd1 << PWM_BITS) - 64'd1);

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEIL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL    = 3'd7;

  // reset values
  localparam logic [ADC_BITS-1:0] RST_ADC_MIN   = ADC_BITS'(820);
  localparam logic [ADC_BITS-1:0] RST_ADC_MAX   = ADC_BITS'(3450);
  localparam logic [ALPHA_W-1:0]  RST_ALPHA     = 16'd3277;
  localparam logic [DUTY_W-1:0]   RST_GAIN      = 32'd457259;
  localparam logic [DUTY_W-1:0]   RST_DUTY_CEIL = 32'd1202590843;
  localparam logic [RAMP_W-1:0]   RST_RAMP_UP   = 16'd3436;
  localparam logic [RAMP_W-1:0]   RST_RAMP_DOWN = 16'd8590;
  localparam logic [IVL_W-1:0]    RST_MAX_IVL   = 20'd100000;

  typedef struct packed {
    logic [ADC_BITS-1:0] adc_min;
    logic [ADC_BITS-1:0] adc_max;
    logic [ALPHA_W-1:0]  filter_alpha;
    logic [DUTY_W-1:0]   command_gain;
    logic [DUTY_W-1:0]   duty_ceil;
    logic [RAMP_W-1:0]   ramp_up_per_us;
    logic [RAMP_W-1:0]   ramp_down_per_us;
    logic [IVL_W-1:0]    max_interval_us;
  } cfg_t;

  // datapath commands, one per controller step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,   // take tick: interval, timestamp, clamped sample
    OP_PAVG,   // average error magnitude and sign
    OP_MAVG,   // error * alpha
    OP_FAVG,   // update average
    OP_PTGT,   // average above zero point
    OP_MTGT,   // excess * gain
    OP_TGT,    // clamp target duty
    OP_STEP,   // direction and distance to target
    OP_MLIM,   // ramp * interval
    OP_DUTY,   // move duty
    OP_CLMP,   // duty ceiling
    OP_MPWM,   // duty * PWM full scale
    OP_OUT     // load result register
  } dp_op_e;

endpackage

// ===== rtl/tfsl_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsl_cfg
// Configuration register bank, written by index, no read-back.
// ----------------------------------------------------------------------------
module tfsl_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tfsl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tfsl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output tfsl_pkg::cfg_t                     cfg_o
);

  tfsl_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfsl_pkg::CFG_ADC_MIN:
          cfg_d.adc_min = cfg_wdata_i[tfsl_pkg::ADC_BITS-1:0];
        tfsl_pkg::CFG_ADC_MAX:
          cfg_d.adc_max = cfg_wdata_i[tfsl_pkg::ADC_BITS-1:0];
        tfsl_pkg::CFG_ALPHA:
          cfg_d.filter_alpha = cfg_wdata_i[tfsl_pkg::ALPHA_W-1:0];
        tfsl_pkg::CFG_GAIN:
          cfg_d.command_gain = cfg_wdata_i[tfsl_pkg::DUTY_W-1:0];
        tfsl_pkg::CFG_DUTY_CEIL:
          cfg_d.duty_ceil = cfg_wdata_i[tfsl_pkg::DUTY_W-1:0];
        tfsl_pkg::CFG_RAMP_UP:
          cfg_d.ramp_up_per_us = cfg_wdata_i[tfsl_pkg::RAMP_W-1:0];
        tfsl_pkg::CFG_RAMP_DOWN:
          cfg_d.ramp_down_per_us = cfg_wdata_i[tfsl_pkg::RAMP_W-1:0];
        tfsl_pkg::CFG_MAX_IVL:
          cfg_d.max_interval_us = cfg_wdata_i[tfsl_pkg::IVL_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_min          <= tfsl_pkg::RST_ADC_MIN;
      cfg_q.adc_max          <= tfsl_pkg::RST_ADC_MAX;
      cfg_q.filter_alpha     <= tfsl_pkg::RST_ALPHA;
      cfg_q.command_gain     <= tfsl_pkg::RST_GAIN;
      cfg_q.duty_ceil        <= tfsl_pkg::RST_DUTY_CEIL;
      cfg_q.ramp_up_per_us   <= tfsl_pkg::RST_RAMP_UP;
      cfg_q.ramp_down_per_us <= tfsl_pkg::RST_RAMP_DOWN;
      cfg_q.max_interval_us  <= tfsl_pkg::RST_MAX_IVL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tfsl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsl_ctrl
// Step sequencer: one datapath op per cycle, stalls at OUT; owns out valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfsl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic             skip_i,
  output tfsl_pkg::dp_op_e op_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PAVG = 4'd1;
  localparam logic [3:0] ST_MAVG = 4'd2;
  localparam logic [3:0] ST_FAVG = 4'd3;
  localparam logic [3:0] ST_PTGT = 4'd4;
  localparam logic [3:0] ST_MTGT = 4'd5;
  localparam logic [3:0] ST_TGT  = 4'd6;
  localparam logic [3:0] ST_STEP = 4'd7;
  localparam logic [3:0] ST_MLIM = 4'd8;
  localparam logic [3:0] ST_DUTY = 4'd9;
  localparam logic [3:0] ST_CLMP = 4'd10;
  localparam logic [3:0] ST_MPWM = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    op_o       = tfsl_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o = tfsl_pkg::OP_LOAD;
          if (!skip_i) begin
            state_d = ST_PAVG;
          end
        end
      end
      ST_PAVG: begin
        op_o    = tfsl_pkg::OP_PAVG;
        state_d = ST_MAVG;
      end
      ST_MAVG: begin
        op_o    = tfsl_pkg::OP_MAVG;
        state_d = ST_FAVG;
      end
      ST_FAVG: begin
        op_o    = tfsl_pkg::OP_FAVG;
        state_d = ST_PTGT;
      end
      ST_PTGT: begin
        op_o    = tfsl_pkg::OP_PTGT;
        state_d = ST_MTGT;
      end
      ST_MTGT: begin
        op_o    = tfsl_pkg::OP_MTGT;
        state_d = ST_TGT;
      end
      ST_TGT: begin
        op_o    = tfsl_pkg::OP_TGT;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        op_o    = tfsl_pkg::OP_STEP;
        state_d = ST_MLIM;
      end
      ST_MLIM: begin
        op_o    = tfsl_pkg::OP_MLIM;
        state_d = ST_DUTY;
      end
      ST_DUTY: begin
        op_o    = tfsl_pkg::OP_DUTY;
        state_d = ST_CLMP;
      end
      ST_CLMP: begin
        op_o    = tfsl_pkg::OP_CLMP;
        state_d = ST_MPWM;
      end
      ST_MPWM: begin
        op_o    = tfsl_pkg::OP_MPWM;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // wait here until the result register is free
        if (out_free) begin
          op_o    = tfsl_pkg::OP_OUT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (op_o == tfsl_pkg::OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `TFSL_ASSERT(a_out_load_sets_valid, (op_o == tfsl_pkg::OP_OUT) |=> out_valid_q)
  `TFSL_ASSERT(a_live_tick_starts, (op_o == tfsl_pkg::OP_LOAD) && !skip_i |=> state_q == ST_PAVG)
  `TFSL_ASSERT(a_valid_from_out_step, $rose(out_valid_q) |-> $past(state_q == ST_OUT))

endmodule

// ===== rtl/tfsl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsl_dp
// Filter and slew datapath around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfsl_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tfsl_pkg::dp_op_e                   op_i,
  input  tfsl_pkg::cfg_t                     cfg_i,
  input  logic [tfsl_pkg::TIME_W-1:0]        time_us_i,
  input  logic [tfsl_pkg::ADC_BITS-1:0]      adc_sample_i,
  output logic                               skip_o,
  output logic [tfsl_pkg::PWM_BITS-1:0]      pwm_level_o,
  output logic [tfsl_pkg::DUTY_W-1:0]        duty_fraction_o
);

  // model state
  logic [tfsl_pkg::TIME_W-1:0]   last_q, last_d;
  logic [tfsl_pkg::FILT_W-1:0]   filt_q, filt_d;
  logic [tfsl_pkg::DUTY_W-1:0]   duty_q, duty_d;

  // per-tick working registers
  logic [tfsl_pkg::TIME_W-1:0]   dt_q, dt_d;
  logic [tfsl_pkg::ADC_BITS-1:0] samp_q, samp_d;
  logic [tfsl_pkg::FILT_W-1:0]   diff_q, diff_d;
  logic                          up_q, up_d;
  logic                          pos_q, pos_d;
  logic                          rise_q, rise_d;
  logic [tfsl_pkg::DUTY_W-1:0]   tgt_q, tgt_d;
  logic [tfsl_pkg::DUTY_W-1:0]   step_q, step_d;
  logic [tfsl_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic [tfsl_pkg::PWM_BITS-1:0] pwm_q, pwm_d;
  logic [tfsl_pkg::DUTY_W-1:0]   dfrac_q, dfrac_d;

  logic [tfsl_pkg::TIME_W-1:0]   dt_now;
  logic [tfsl_pkg::ADC_BITS-1:0] samp_cl;
  logic [tfsl_pkg::FILT_W-1:0]   goal, zero_pt, avg_inc, avg_dec;
  logic [tfsl_pkg::TGT_W-1:0]    tgt_raw;
  logic [tfsl_pkg::LIM_W-1:0]    lim;
  logic [tfsl_pkg::DUTY_W-1:0]   move;
  logic [tfsl_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [tfsl_pkg::PROD_W-1:0]   mul_p;

  assign dt_now = time_us_i - last_q;
  assign skip_o = (dt_now == '0) ||
                  (dt_now > tfsl_pkg::TIME_W'(cfg_i.max_interval_us));

  // inverted window: low bound checked first, all samples at or above it get the high bound
  always_comb begin
    priority if (adc_sample_i < cfg_i.adc_min) begin
      samp_cl = cfg_i.adc_min;
    end else if (adc_sample_i > cfg_i.adc_max) begin
      samp_cl = cfg_i.adc_max;
    end else begin
      samp_cl = adc_sample_i;
    end
  end

  assign goal    = {samp_q, {tfsl_pkg::FRAC_BITS{1'b0}}};
  assign zero_pt = {cfg_i.adc_min, {tfsl_pkg::FRAC_BITS{1'b0}}};
  // downward step rounds toward minus infinity: ceil of the magnitude
  assign avg_inc = prod_q[tfsl_pkg::FRAC_BITS +: tfsl_pkg::FILT_W];
  assign avg_dec = avg_inc + tfsl_pkg::FILT_W'(|prod_q[tfsl_pkg::FRAC_BITS-1:0]);
  assign tgt_raw = prod_q[tfsl_pkg::FRAC_BITS +: tfsl_pkg::TGT_W];
  assign lim     = prod_q[tfsl_pkg::LIM_W-1:0];
  assign move    = (tfsl_pkg::LIM_W'(step_q) < lim) ? step_q
                                                    : lim[tfsl_pkg::DUTY_W-1:0];

  // shared multiplier operand select
  always_comb begin
    unique case (op_i)
      tfsl_pkg::OP_MAVG: begin
        mul_a = tfsl_pkg::MUL_W'(diff_q);
        mul_b = tfsl_pkg::MUL_W'(cfg_i.filter_alpha);
      end
      tfsl_pkg::OP_MTGT: begin
        mul_a = tfsl_pkg::MUL_W'(diff_q);
        mul_b = cfg_i.command_gain;
      end
      tfsl_pkg::OP_MLIM: begin
        mul_a = dt_q;
        mul_b = rise_q ? tfsl_pkg::MUL_W'(cfg_i.ramp_up_per_us)
                       : tfsl_pkg::MUL_W'(cfg_i.ramp_down_per_us);
      end
      default: begin
        mul_a = duty_q;
        mul_b = tfsl_pkg::PWM_MAX;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    last_d  = last_q;
    filt_d  = filt_q;
    duty_d  = duty_q;
    dt_d    = dt_q;
    samp_d  = samp_q;
    diff_d  = diff_q;
    up_d    = up_q;
    pos_d   = pos_q;
    rise_d  = rise_q;
    tgt_d   = tgt_q;
    step_d  = step_q;
    prod_d  = prod_q;
    pwm_d   = pwm_q;
    dfrac_d = dfrac_q;
    unique case (op_i)
      tfsl_pkg::OP_LOAD: begin
        last_d = time_us_i;
        dt_d   = dt_now;
        samp_d = samp_cl;
      end
      tfsl_pkg::OP_PAVG: begin
        up_d   = goal >= filt_q;
        diff_d = (goal >= filt_q) ? goal - filt_q : filt_q - goal;
      end
      tfsl_pkg::OP_MAVG, tfsl_pkg::OP_MTGT, tfsl_pkg::OP_MLIM,
      tfsl_pkg::OP_MPWM: begin
        prod_d = mul_p;
      end
      tfsl_pkg::OP_FAVG: begin
        filt_d = up_q ? filt_q + avg_inc : filt_q - avg_dec;
      end
      tfsl_pkg::OP_PTGT: begin
        pos_d  = filt_q > zero_pt;
        diff_d = filt_q - zero_pt;
      end
      tfsl_pkg::OP_TGT: begin
        priority if (!pos_q) begin
          tgt_d = '0;
        end else if (tgt_raw > tfsl_pkg::TGT_W'(cfg_i.duty_ceil)) begin
          tgt_d = cfg_i.duty_ceil;
        end else begin
          tgt_d = tgt_raw[tfsl_pkg::DUTY_W-1:0];
        end
      end
      tfsl_pkg::OP_STEP: begin
        rise_d = duty_q < tgt_q;
        step_d = (duty_q < tgt_q) ? tgt_q - duty_q : duty_q - tgt_q;
      end
      tfsl_pkg::OP_DUTY: begin
        duty_d = rise_q ? duty_q + move : duty_q - move;
      end
      tfsl_pkg::OP_CLMP: begin
        duty_d = (duty_q > cfg_i.duty_ceil) ? cfg_i.duty_ceil : duty_q;
      end
      tfsl_pkg::OP_OUT: begin
        pwm_d   = prod_q[tfsl_pkg::DUTY_W +: tfsl_pkg::PWM_BITS];
        dfrac_d = duty_q;
      end
      default: begin
        last_d = last_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      filt_q <= '0;
      duty_q <= '0;
    end else begin
      last_q <= last_d;
      filt_q <= filt_d;
      duty_q <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    samp_q  <= samp_d;
    diff_q  <= diff_d;
    up_q    <= up_d;
    pos_q   <= pos_d;
    rise_q  <= rise_d;
    tgt_q   <= tgt_d;
    step_q  <= step_d;
    prod_q  <= prod_d;
    pwm_q   <= pwm_d;
    dfrac_q <= dfrac_d;
  end

  assign pwm_level_o     = pwm_q;
  assign duty_fraction_o = dfrac_q;

  `TFSL_ASSERT(a_duty_under_ceiling, (op_i == tfsl_pkg::OP_CLMP) |=> duty_q <= $past(cfg_i.duty_ceil))
  `TFSL_ASSERT(a_duty_no_overshoot, (op_i == tfsl_pkg::OP_DUTY) |=> (rise_q ? duty_q <= tgt_q : duty_q >= tgt_q))

endmodule

// ===== rtl/throttle_filter_slew_limiter.sv =====
`timescale 1ns / 1ps
// Each live tick is walked by the step sequencer through one shared 32x32
// multiplier (four products a tick) before out_valid_o rises; a new tick is
// taken only once the previous result is loaded into the result register.
// A dropped tick (zero or too long interval) saves its time and gives no result.
// Reset: async active low; model state to zero, config registers to defaults.
// ----------------------------------------------------------------------------
// throttle_filter_slew_limiter
// Throttle sample average, linear duty map and asymmetric slew limit.
// ----------------------------------------------------------------------------
module throttle_filter_slew_limiter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tick input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [tfsl_pkg::TIME_W-1:0]        time_us_i,
  input  logic [tfsl_pkg::ADC_BITS-1:0]      adc_sample_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tfsl_pkg::PWM_BITS-1:0]      pwm_level_o,
  output logic [tfsl_pkg::DUTY_W-1:0]        duty_fraction_o,
  // register writes
  input  logic                               cfg_we_i,
  input  logic [tfsl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tfsl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  tfsl_pkg::cfg_t   cfg;
  tfsl_pkg::dp_op_e op;
  logic             skip;

  // Register bank. Writes are expected only while no tick is in flight.
  tfsl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer: ready only in idle. A tick transfer always stores the new
  // timestamp; if the interval is out of range it stays idle, otherwise it
  // steps average -> target -> slew -> PWM scale, then waits for the result
  // register to free up. The result register lets the next tick transfer
  // while the previous result is still pending downstream.
  tfsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .skip_i      (skip),
    .op_o        (op)
  );

  // Datapath: interval and clamp on transfer, then one register stage after
  // every product. Average Q12.16, duty Q0.32, PWM level = duty * full scale
  // taken from the upper product word.
  tfsl_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .cfg_i           (cfg),
    .time_us_i       (time_us_i),
    .adc_sample_i    (adc_sample_i),
    .skip_o          (skip),
    .pwm_level_o     (pwm_level_o),
    .duty_fraction_o (duty_fraction_o)
  );

endmodule
